FILE: rtl/sdrs_pkg.sv
// Package for the SSTF disk request scheduler.
// Word types, controller/datapath command and status structs, fixed widths.
// No dependencies.
package sdrs_pkg;

    localparam int CYL_W    = 12;
    localparam int SEEK_W   = 18;
    localparam int CYL_WIDE = 16;

    localparam logic [SEEK_W-1:0] SEEK_MAX = {SEEK_W{1'b1}};

    typedef struct packed {
        logic [CYL_W-1:0] cylinder_request;
        logic             batch_end;
    } t_req;

    typedef struct packed {
        logic [CYL_W-1:0]  served_cylinder;
        logic [SEEK_W-1:0] running_seek;
        logic              run_end;
        logic              dropped_flag;
    } t_res;

    typedef struct packed {
        logic load;
        logic start_batch;
        logic issue;
        logic swap;
    } t_cmd;

    typedef struct packed {
        logic last_issue;
        logic last_step;
    } t_sts;

endpackage

FILE: rtl/sstf_disk_request_scheduler.sv
// Shortest-seek-time-first disk request scheduler, top level.
// Depends on sdrs_pkg, sdrs_ctrl, sdrs_dp (which holds sdrs_ram).
//
// Requests are taken one per cycle while busy is low; each is stored in the slot
// RAM (up to MAX_REQUESTS, the rest dropped and flagged). The request with
// batch_end raises busy the next cycle and starts scheduling from the configured
// start cylinder. Step i of a batch of n requests scans the n-i remaining slots
// through the single read port of the slot RAM, one slot per cycle, then passes
// through the drain and swap states to finish the compare and swap; its result
// word appears for one cycle on o_res with o_res_strobe. Busy falls with the word
// that carries run_end. Results cannot be stalled.
// The configuration write is always ready and must only be used while idle.
module sstf_disk_request_scheduler #(
    parameter int MAX_REQUESTS  = 64,
    parameter int CYLINDER_BITS = 12
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  sdrs_pkg::t_req             i_req,
    output logic                       o_res_strobe,
    output sdrs_pkg::t_res             o_res,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [sdrs_pkg::CYL_W-1:0] i_cfg_data
);

    sdrs_pkg::t_cmd cmd;
    sdrs_pkg::t_sts sts;

    sdrs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_batch_end (i_req.batch_end),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_busy      (busy)
    );

    sdrs_dp #(
        .MAX_REQUESTS  (MAX_REQUESTS),
        .CYLINDER_BITS (CYLINDER_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_req        (i_req),
        .i_cfg_valid  (i_cfg_valid && o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_sts        (sts),
        .o_res        (o_res),
        .o_res_strobe (o_res_strobe)
    );

    assign o_cfg_ready = 1'b1;

    a_strobe_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |-> $past(busy))
        else $error("result word outside a batch");

    a_end_drops_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && o_res.run_end) |-> !busy)
        else $error("busy still high after last word");

    a_mid_keeps_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && !o_res.run_end) |-> busy)
        else $error("busy dropped before last word");

    a_load_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_req.batch_end) |=> !busy)
        else $error("busy without batch end");

endmodule

FILE: rtl/sdrs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sdrs_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/sdrs_ctrl.sv
// Scheduler controller: load / scan / drain / swap sequencing and busy.
// Depends on sdrs_pkg.
module sdrs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_batch_end,
    input  sdrs_pkg::t_sts i_sts,
    output sdrs_pkg::t_cmd o_cmd,
    output logic          o_busy
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_SWAP
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy;
    sdrs_pkg::t_cmd cmd;

    always_comb begin
        cmd.load        = (r_state == S_IDLE) && i_start;
        cmd.start_batch = cmd.load && i_batch_end;
        cmd.issue       = (r_state == S_SCAN);
        cmd.swap        = (r_state == S_SWAP);
    end

    always_comb begin
        n_state = r_state;
        n_busy  = r_busy;
        unique case (r_state)
            S_IDLE: begin
                if (cmd.start_batch) begin
                    n_state = S_SCAN;
                    n_busy  = 1'b1;
                end
            end
            S_SCAN: begin
                if (i_sts.last_issue) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_SWAP;
            end
            S_SWAP: begin
                if (i_sts.last_step) begin
                    n_state = S_IDLE;
                    n_busy  = 1'b0;
                end else begin
                    n_state = S_SCAN;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_busy  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    assign o_cmd  = cmd;
    assign o_busy = r_busy;

endmodule

FILE: rtl/sdrs_dp.sv
// Scheduler datapath: slot RAM, request count, nearest-slot search, seek sum,
// result register. Depends on sdrs_pkg and sdrs_ram.
module sdrs_dp #(
    parameter int MAX_REQUESTS  = 64,
    parameter int CYLINDER_BITS = 12
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sdrs_pkg::t_cmd              i_cmd,
    input  sdrs_pkg::t_req              i_req,
    input  logic                        i_cfg_valid,
    input  logic [sdrs_pkg::CYL_W-1:0]  i_cfg_data,
    output sdrs_pkg::t_sts              o_sts,
    output sdrs_pkg::t_res              o_res,
    output logic                        o_res_strobe
);

    localparam int AW   = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int CNTW = $clog2(MAX_REQUESTS + 1);
    localparam int CW   = CYLINDER_BITS;

    logic [CNTW-1:0]               r_count;
    logic                          r_ovf;
    logic [CW-1:0]                 r_head;
    logic [sdrs_pkg::SEEK_W-1:0]   r_seek;
    logic [AW-1:0]                 r_i, r_j, r_rd_idx, r_best;
    logic                          r_rd_vld;
    logic [CW-1:0]                 r_best_d, r_best_val, r_first_val;
    logic [sdrs_pkg::CYL_W-1:0]    r_start_cyl;
    sdrs_pkg::t_res                r_out;
    logic                          r_out_vld;

    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic [CW-1:0]                 ram_wdata, ram_rdata;

    logic [sdrs_pkg::CYL_WIDE-1:0] req_wide, start_wide, served_wide;
    logic [CW-1:0]                 req_cyl, start_cyl, gap;
    logic                          full, first, take;
    logic [sdrs_pkg::SEEK_W:0]     seek_sum;
    logic [sdrs_pkg::SEEK_W-1:0]   seek_sat;
    sdrs_pkg::t_sts                sts;

    sdrs_ram #(
        .WIDTH (CW),
        .DEPTH (MAX_REQUESTS)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_j),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        req_wide    = sdrs_pkg::CYL_WIDE'(i_req.cylinder_request);
        req_cyl     = req_wide[CW-1:0];
        start_wide  = sdrs_pkg::CYL_WIDE'(r_start_cyl);
        start_cyl   = start_wide[CW-1:0];
        served_wide = sdrs_pkg::CYL_WIDE'(r_best_val);

        full  = (r_count == CNTW'(MAX_REQUESTS));
        gap   = (r_head >= ram_rdata) ? (r_head - ram_rdata) : (ram_rdata - r_head);
        first = (r_rd_idx == r_i);
        take  = r_rd_vld && (first || (gap <= r_best_d));

        seek_sum = {1'b0, r_seek} + (sdrs_pkg::SEEK_W + 1)'(r_best_d);
        seek_sat = seek_sum[sdrs_pkg::SEEK_W] ? sdrs_pkg::SEEK_MAX
                                              : seek_sum[sdrs_pkg::SEEK_W-1:0];

        sts.last_issue = ((CNTW'(r_j) + CNTW'(1)) == r_count);
        sts.last_step  = ((CNTW'(r_i) + CNTW'(1)) == r_count);

        if (i_cmd.swap) begin
            ram_we    = 1'b1;
            ram_waddr = r_best;
            ram_wdata = r_first_val;
        end else begin
            ram_we    = i_cmd.load && !full;
            ram_waddr = r_count[AW-1:0];
            ram_wdata = req_cyl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_i         <= '0;
            r_j         <= '0;
            r_rd_vld    <= 1'b0;
            r_out_vld   <= 1'b0;
            r_start_cyl <= '0;
            r_head      <= '0;
        end else begin
            r_rd_vld  <= i_cmd.issue;
            r_out_vld <= i_cmd.swap;
            if (i_cfg_valid) begin
                r_start_cyl <= i_cfg_data;
            end
            if (i_cmd.load) begin
                if (!full) begin
                    r_count <= r_count + CNTW'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.start_batch) begin
                r_i    <= '0;
                r_j    <= '0;
                r_head <= start_cyl;
            end
            if (i_cmd.issue) begin
                r_j <= r_j + AW'(1);
            end
            if (i_cmd.swap) begin
                r_head <= r_best_val;
                if (sts.last_step) begin
                    r_count <= '0;
                    r_ovf   <= 1'b0;
                end else begin
                    r_i <= r_i + AW'(1);
                    r_j <= r_i + AW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_rd_idx <= r_j;
        end
        if (i_cmd.start_batch) begin
            r_seek <= '0;
        end
        if (take) begin
            r_best     <= r_rd_idx;
            r_best_d   <= gap;
            r_best_val <= ram_rdata;
        end
        if (r_rd_vld && first) begin
            r_first_val <= ram_rdata;
        end
        if (i_cmd.swap) begin
            r_seek                <= seek_sat;
            r_out.served_cylinder <= served_wide[sdrs_pkg::CYL_W-1:0];
            r_out.running_seek    <= seek_sat;
            r_out.run_end         <= sts.last_step;
            r_out.dropped_flag    <= r_ovf;
        end
    end

    assign o_sts        = sts;
    assign o_res        = r_out;
    assign o_res_strobe = r_out_vld;

endmodule
